/* src/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/wwls_pkg.sv */
// Package: shared types and constants of the weighted win/loss sweep.
package wwls_pkg;

   localparam int ENTRIES_DEF     = 1024;
   localparam int TIME_BITS_DEF   = 32;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam logic [62:0] SAT_MAX = {63{1'b1}};

   typedef enum logic [1:0] {
      CMD_LOAD_HIGH = 2'd0,
      CMD_LOAD_LOW  = 2'd1,
      CMD_FINISH    = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_HIGH,
      KIND_LOW,
      KIND_FINISH,
      KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] time_req;
      logic        status;
      logic [15:0] weight;
   } req_type;

   typedef struct packed {
      logic [62:0] wins;
      logic [62:0] losses;
      logic        overflow;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] time_req;
      logic        status;
      logic [15:0] weight;
   } item_type;

   // Back-end status seen by the top level checks.
   typedef struct packed {
      logic busy;
      logic high_ok;
      logic low_ok;
      logic counts_zero;
   } stat_type;

endpackage

/* src/wwls_front.sv */
// Front end: accepts request items, classifies them and queues all but unused commands.
module wwls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wwls_pkg::req_type req,
   output logic              q_valid,
   output wwls_pkg::item_type q_item,
   input  logic              q_ready
);
   import wwls_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   cls;
   logic       push, pop;

   // Decode the command into an item kind
   always_comb begin
      cls.time_req = req.time_req;
      cls.status   = req.status;
      cls.weight   = req.weight;
      unique case (cmd_type'(req.command))
         CMD_LOAD_HIGH: cls.kind = KIND_HIGH;
         CMD_LOAD_LOW:  cls.kind = KIND_LOW;
         CMD_FINISH:    cls.kind = KIND_FINISH;
         default:       cls.kind = KIND_NOP;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && (cls.kind != KIND_NOP);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign pop       = q_valid && q_ready;

   // Two-entry queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* src/wwls_back.sv */
// Back end: entry stores, pairwise sweep, serial multiply and result register.
module wwls_back #(
   parameter int ENTRIES     = wwls_pkg::ENTRIES_DEF,
   parameter int TIME_BITS   = wwls_pkg::TIME_BITS_DEF,
   parameter int WEIGHT_BITS = wwls_pkg::WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  wwls_pkg::item_type q_item,
   output logic               q_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wwls_pkg::rsp_type  rsp,
   output wwls_pkg::stat_type stat
);
   import wwls_pkg::*;

   localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int EW     = TIME_BITS + 1 + WEIGHT_BITS;
   localparam int SUM_W  = WEIGHT_BITS + CNT_W;
   localparam int PROD_W = WEIGHT_BITS + SUM_W;
   localparam int BC_W   = $clog2(WEIGHT_BITS);
   localparam int EXT_W  = 96;

   logic [EW-1:0] mem_high [ENTRIES];
   logic [EW-1:0] mem_low  [ENTRIES];
   logic [EW-1:0] rd_high_ff, rd_low_ff;
   logic [AW-1:0] addr_high, addr_low;
   logic          we_high, we_low;
   logic [EW-1:0] wr_entry;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  high_cnt_ff, high_cnt_in, low_cnt_ff, low_cnt_in;
   logic              dropped_ff, dropped_in;
   logic              pass_ff, pass_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic              pipe_v_ff, pipe_v_in;
   logic [SUM_W-1:0]  later_ff, later_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic [WEIGHT_BITS-1:0] mplier_ff, mplier_in;
   logic [BC_W-1:0]   bit_ff, bit_in;
   logic [62:0]       acc_ff, acc_in, wins_ff, wins_in, losses_ff, losses_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  n_oth, n_sc;
   logic [EW-1:0]     sc_e, oth_e;
   logic [PROD_W-1:0] prod_fin;
   logic [EXT_W-1:0]  prod_ext;
   logic [62:0]       p63;
   logic [63:0]       sum64;
   logic [62:0]       acc_new;

   // Scorer side is low on the wins pass, high on the losses pass
   assign n_oth     = pass_ff ? low_cnt_ff : high_cnt_ff;
   assign n_sc      = pass_ff ? high_cnt_ff : low_cnt_ff;
   assign sc_e      = pass_ff ? rd_high_ff : rd_low_ff;
   assign oth_e     = pass_ff ? rd_low_ff : rd_high_ff;
   assign wr_entry  = {TIME_BITS'(q_item.time_req), q_item.status,
                       WEIGHT_BITS'(q_item.weight)};

   // Product finish and saturating accumulate
   assign prod_fin = prod_ff + (mplier_ff[0] ? mcand_ff : PROD_W'(0));
   assign prod_ext = EXT_W'(prod_fin);
   assign p63      = (|prod_ext[EXT_W-1:63]) ? SAT_MAX : prod_ext[62:0];
   assign sum64    = {1'b0, acc_ff} + {1'b0, p63};
   assign acc_new  = sum64[63] ? SAT_MAX : sum64[62:0];

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      high_cnt_in  = high_cnt_ff;
      low_cnt_in   = low_cnt_ff;
      dropped_in   = dropped_ff;
      pass_in      = pass_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pipe_v_in    = 1'b0;
      later_in     = later_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      mplier_in    = mplier_ff;
      bit_in       = bit_ff;
      acc_in       = acc_ff;
      wins_in      = wins_ff;
      losses_in    = losses_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_ready      = 1'b0;
      we_high      = 1'b0;
      we_low       = 1'b0;
      addr_high    = pass_ff ? j_ff[AW-1:0] : i_ff[AW-1:0];
      addr_low     = pass_ff ? i_ff[AW-1:0] : j_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               case (q_item.kind)
                  KIND_HIGH: begin
                     if (high_cnt_ff == CNT_W'(ENTRIES)) begin
                        dropped_in = 1'b1;
                     end else begin
                        we_high     = 1'b1;
                        addr_high   = high_cnt_ff[AW-1:0];
                        high_cnt_in = high_cnt_ff + 1'b1;
                     end
                  end
                  KIND_LOW: begin
                     if (low_cnt_ff == CNT_W'(ENTRIES)) begin
                        dropped_in = 1'b1;
                     end else begin
                        we_low     = 1'b1;
                        addr_low   = low_cnt_ff[AW-1:0];
                        low_cnt_in = low_cnt_ff + 1'b1;
                     end
                  end
                  KIND_FINISH: begin
                     wins_in   = '0;
                     losses_in = '0;
                     acc_in    = '0;
                     pass_in   = 1'b0;
                     i_in      = '0;
                     j_in      = '0;
                     later_in  = '0;
                     if (high_cnt_ff == '0 || low_cnt_ff == '0) begin
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Stream the other group past the held scorer entry
         ST_SCAN: begin
            if (pipe_v_ff && (oth_e[EW-1 -: TIME_BITS] > sc_e[EW-1 -: TIME_BITS])) begin
               later_in = later_ff + SUM_W'(oth_e[WEIGHT_BITS-1:0]);
            end
            if (i_ff < n_oth) begin
               pipe_v_in = 1'b1;
               i_in      = i_ff + 1'b1;
            end else if (!pipe_v_ff) begin
               mcand_in  = PROD_W'(later_ff);
               mplier_in = sc_e[WEIGHT_BITS] ? sc_e[WEIGHT_BITS-1:0] : '0;
               prod_in   = '0;
               bit_in    = '0;
               state_in  = ST_MUL;
            end
         end
         // Shift-add multiply, one weight bit per cycle
         ST_MUL: begin
            prod_in   = prod_fin;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            bit_in    = bit_ff + 1'b1;
            if (bit_ff == BC_W'(WEIGHT_BITS - 1)) begin
               acc_in   = acc_new;
               j_in     = j_ff + 1'b1;
               i_in     = '0;
               later_in = '0;
               state_in = ST_SCAN;
               if (j_ff + 1'b1 == n_sc) begin
                  j_in = '0;
                  if (!pass_ff) begin
                     wins_in = acc_new;
                     acc_in  = '0;
                     pass_in = 1'b1;
                  end else begin
                     losses_in = acc_new;
                     state_in  = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_in.wins     = wins_ff;
               rsp_in.losses   = losses_ff;
               rsp_in.overflow = dropped_ff;
               high_cnt_in     = '0;
               low_cnt_in      = '0;
               dropped_in      = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         high_cnt_ff  <= '0;
         low_cnt_ff   <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pipe_v_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         high_cnt_ff  <= high_cnt_in;
         low_cnt_ff   <= low_cnt_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         pipe_v_ff    <= pipe_v_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pass_ff   <= pass_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      later_ff  <= later_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      mplier_ff <= mplier_in;
      bit_ff    <= bit_in;
      acc_ff    <= acc_in;
      wins_ff   <= wins_in;
      losses_ff <= losses_in;
      rsp_ff    <= rsp_in;
   end

   // Entry stores, one port each, registered read
   always_ff @(posedge clock) begin
      if (we_high) begin
         mem_high[addr_high] <= wr_entry;
      end
      rd_high_ff <= mem_high[addr_high];
   end

   always_ff @(posedge clock) begin
      if (we_low) begin
         mem_low[addr_low] <= wr_entry;
      end
      rd_low_ff <= mem_low[addr_low];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp              = rsp_ff;
   assign stat.busy        = (state_ff != ST_IDLE);
   assign stat.high_ok     = (high_cnt_ff <= CNT_W'(ENTRIES));
   assign stat.low_ok      = (low_cnt_ff <= CNT_W'(ENTRIES));
   assign stat.counts_zero = (high_cnt_ff == '0) && (low_cnt_ff == '0) && !dropped_ff;

endmodule

/* src/weighted_win_loss_sweep_top.sv */
// Top level of the weighted win/loss sweep: front queue, back end, checks.
//
// Request items on req_*: command 0 loads a high-group entry, 1 a low-group
// entry, 2 finishes; command 3 is taken and ignored. A load gives no result.
// A finish gives one result item on rsp_*: weighted wins, weighted losses
// (16 fractional bits, saturating) and an overflow bit for dropped loads.
// Loads enter at one per cycle while the back end is idle, through a two-item
// queue into the back end, which writes one store entry per cycle.
// For a finish, each scorer entry sweeps the other store through its single
// read port, then a shift-add multiplier takes one weight bit per cycle. If
// either group is empty, the finish gives zeros without a sweep.
// While a finish runs, the queue holds up to two more items and then drops
// req_ready. The result waits in an output register; a stalled receiver
// holds the back end only when the next result is ready.
// Reset empties both groups, clears the flag and the queue; store contents
// need no clearing.
module weighted_win_loss_sweep_top #(
   parameter int ENTRIES     = wwls_pkg::ENTRIES_DEF,
   parameter int TIME_BITS   = wwls_pkg::TIME_BITS_DEF,
   parameter int WEIGHT_BITS = wwls_pkg::WEIGHT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wwls_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wwls_pkg::rsp_type rsp
);
   import wwls_pkg::*;
   `include "assert_macros.svh"

   logic     q_valid, q_ready;
   item_type q_item;
   stat_type stat;

   wwls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_ready   (q_ready)
   );

   wwls_back #(
      .ENTRIES     (ENTRIES),
      .TIME_BITS   (TIME_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_ready   (q_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .stat      (stat)
   );

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset || (stat.high_ok && stat.low_ok), "group count past capacity")
   `ASSERT_RST(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> $past(stat.busy), "result without finish")
   `ASSERT_RST(a_clear_on_rsp, clock, reset, $rose(rsp_valid) |-> stat.counts_zero, "groups not cleared")

endmodule
